/* rtl/core/union_find_maze_carver_defines.svh */
// assertion macros for the maze carver checker
// expects clk and rst to be visible where a macro is used
`ifndef UNION_FIND_MAZE_CARVER_DEFINES_SVH
`define UNION_FIND_MAZE_CARVER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UFMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ufmc assertion failed");

// next-cycle implication, checked outside reset
`define UFMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ufmc assertion failed");

`endif

/* rtl/core/ufmc_pkg.sv */
// shared widths and codes for the union-find maze carver
// used by the top level, the index unit and the port checker
package ufmc_pkg;

  localparam int unsigned CFG_W   = 7;   // grid size registers
  localparam int unsigned COORD_W = 6;   // cell coordinates
  localparam int unsigned WALL_W  = 7;   // wall tile coordinates
  localparam int unsigned PROD_W  = 14;  // multiply-add result, 127*127+63 fits
  localparam int unsigned REG_IDX_W = 1;

  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_JOIN  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

endpackage

/* rtl/core/ufmc_mul_add.sv */
// registered multiply-add used for cell indices and clear length
// depends on ufmc_pkg
module ufmc_mul_add (
  input  logic                         clk,
  input  logic [ufmc_pkg::CFG_W-1:0]   mul_a,
  input  logic [ufmc_pkg::CFG_W-1:0]   mul_b,
  input  logic [ufmc_pkg::COORD_W-1:0] add_c,
  output logic [ufmc_pkg::PROD_W-1:0]  prod
);
  import ufmc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b) + PROD_W'(add_c);
  end

endmodule

/* rtl/core/ufmc_link_ram.sv */
// parent link memory: one write port, one read port, registered read data
// no package dependency
module ufmc_link_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [ADDR_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [ADDR_W-1:0] rdata
);

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/union_find_maze_carver.sv */
// top level of the union-find maze carver: sequencer, config registers, result register
// depends on ufmc_pkg, ufmc_mul_add and ufmc_link_ram
//
// Disjoint-set engine for Kruskal maze carving. A clear request makes every cell of the
// current grid its own root; a join request finds both cell roots with full path
// compression, links the first root under the second when they differ and reports the
// wall tile (first_x+second_x+1, first_y+second_y+1). All work runs through one parent
// memory and one shared multiply-add, so one request is in flight at a time. A join
// walks both chains to their roots; a join with a cell outside the grid goes straight to
// the result, and a clear writes every one of the w*h cells of the grid. After reset
// the parent memory is initialized with requests stalled; configuration writes are taken
// throughout. Results wait in an output register, so a new request is taken while the
// previous result is still held.
module union_find_maze_carver #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ufmc_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [ufmc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            cmd,
  input  logic [ufmc_pkg::COORD_W-1:0]    first_x,
  input  logic [ufmc_pkg::COORD_W-1:0]    first_y,
  input  logic [ufmc_pkg::COORD_W-1:0]    second_x,
  input  logic [ufmc_pkg::COORD_W-1:0]    second_y,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic                            carved,
  output logic [ufmc_pkg::WALL_W-1:0]     wall_col,
  output logic [ufmc_pkg::WALL_W-1:0]     wall_row
);
  import ufmc_pkg::*;

  localparam int unsigned CellCount = MAX_COLS * MAX_ROWS;
  localparam int unsigned IdxW      = $clog2(CellCount);
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned ColClip   = (MAX_COLS > 127) ? 127 : MAX_COLS;
  localparam int unsigned RowClip   = (MAX_ROWS > 127) ? 127 : MAX_ROWS;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_IDX_A, S_IDX_B, S_CLR_N, S_CLR,
    S_F_RD, S_F_CHK, S_C_RD, S_C_WR, S_LINK, S_DONE
  } state_t;

  state_t state;

  logic [CFG_W-1:0]   grid_width, grid_height;
  logic [CFG_W-1:0]   eff_w, eff_h;
  logic               out_of_grid;

  logic [COORD_W-1:0] ax, ay, bx, by;
  logic [IdxW-1:0]    start_node, cur_node, root_node, root_a, node_b;
  logic               second;
  logic               carved_hit;
  logic [CntW-1:0]    cnt, clr_len;

  logic [CFG_W-1:0]   mul_a, mul_b;
  logic [COORD_W-1:0] add_c;
  logic [PROD_W-1:0]  prod;

  logic               mem_we;
  logic [IdxW-1:0]    mem_waddr, mem_wdata, mem_rdata;

  // effective grid size: zero acts as one, clipped to the maximum
  assign eff_w = (grid_width == '0) ? CFG_W'(1) :
                 (grid_width > CFG_W'(ColClip)) ? CFG_W'(ColClip) : grid_width;
  assign eff_h = (grid_height == '0) ? CFG_W'(1) :
                 (grid_height > CFG_W'(RowClip)) ? CFG_W'(RowClip) : grid_height;

  assign out_of_grid = ({1'b0, first_x} >= eff_w) || ({1'b0, second_x} >= eff_w) ||
                       ({1'b0, first_y} >= eff_h) || ({1'b0, second_y} >= eff_h);

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_W'(64);
      grid_height <= CFG_W'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiply-add operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    add_c = '0;
    case (state)
      S_IDLE: begin
        if (cmd == CMD_CLEAR) begin
          mul_a = eff_h;
          mul_b = eff_w;
        end else begin
          mul_a = {1'b0, first_y};
          mul_b = eff_w;
          add_c = first_x;
        end
      end
      S_IDX_A: begin
        mul_a = {1'b0, by};
        mul_b = eff_w;
        add_c = bx;
      end
      default: ;
    endcase
  end

  ufmc_mul_add u_mul_add (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .add_c (add_c),
    .prod  (prod)
  );

  // parent memory write port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_node;
    mem_wdata = root_node;
    case (state)
      S_INIT, S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[IdxW-1:0];
        mem_wdata = cnt[IdxW-1:0];
      end
      S_C_WR: mem_we = 1'b1;
      S_LINK: begin
        mem_we    = (root_a != root_node);
        mem_waddr = root_a;
      end
      default: ;
    endcase
  end

  ufmc_link_ram #(
    .DEPTH  (CellCount),
    .ADDR_W (IdxW)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cur_node),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      // the done state reloads the result register itself
      if (res_valid && !res_stall && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          cnt <= cnt + CntW'(1);
          if (cnt == CntW'(CellCount - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            ax     <= first_x;
            ay     <= first_y;
            bx     <= second_x;
            by     <= second_y;
            second <= 1'b0;
            if (cmd == CMD_CLEAR) begin
              state <= S_CLR_N;
            end else if (out_of_grid) begin
              carved_hit <= 1'b0;
              state      <= S_DONE;
            end else begin
              state <= S_IDX_A;
            end
          end
        end
        S_CLR_N: begin
          clr_len <= CntW'(prod);
          cnt     <= '0;
          state   <= S_CLR;
        end
        S_CLR: begin
          cnt <= cnt + CntW'(1);
          if (cnt + CntW'(1) == clr_len) begin
            carved_hit <= 1'b0;
            state      <= S_DONE;
          end
        end
        S_IDX_A: begin
          start_node <= IdxW'(prod);
          cur_node   <= IdxW'(prod);
          state      <= S_IDX_B;
        end
        S_IDX_B: begin
          node_b <= IdxW'(prod);
          state  <= S_F_RD;
        end
        S_F_RD: state <= S_F_CHK;
        S_F_CHK: begin
          // a node that points at itself is the root
          if (mem_rdata == cur_node) begin
            root_node <= cur_node;
            cur_node  <= start_node;
            state     <= S_C_RD;
          end else begin
            cur_node <= mem_rdata;
            state    <= S_F_RD;
          end
        end
        S_C_RD: begin
          if (cur_node == root_node) begin
            if (second) begin
              state <= S_LINK;
            end else begin
              root_a     <= root_node;
              start_node <= node_b;
              cur_node   <= node_b;
              second     <= 1'b1;
              state      <= S_F_RD;
            end
          end else begin
            state <= S_C_WR;
          end
        end
        S_C_WR: begin
          // compress this node onto the root, then follow its old parent
          cur_node <= mem_rdata;
          state    <= S_C_RD;
        end
        S_LINK: begin
          carved_hit <= (root_a != root_node);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid <= 1'b1;
            carved    <= carved_hit;
            wall_col  <= carved_hit ? ({1'b0, ax} + {1'b0, bx} + WALL_W'(1)) : '0;
            wall_row  <= carved_hit ? ({1'b0, ay} + {1'b0, by} + WALL_W'(1)) : '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/ufmc_checker.sv */
// port-level checker for the union-find maze carver, bound to the top level
// depends on union_find_maze_carver_defines.svh and ufmc_pkg
`include "union_find_maze_carver_defines.svh"

module ufmc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input logic                        res_valid,
  input logic                        res_stall,
  input logic                        carved,
  input logic [ufmc_pkg::WALL_W-1:0] wall_col,
  input logic [ufmc_pkg::WALL_W-1:0] wall_row
);
  import ufmc_pkg::*;

  // a held result keeps its payload
  `UFMC_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(carved) && $stable(wall_col) && $stable(wall_row))

  // only one request is in flight
  `UFMC_ASSERT_NEXT(a_busy_after_req, req_valid && !req_stall, req_stall)

  // a result that carved nothing reports no wall tile
  `UFMC_ASSERT_NOW(a_no_carve_zero, res_valid && !carved, wall_col == '0 && wall_row == '0)

  // a carved wall always lies off the tile origin
  `UFMC_ASSERT_NOW(a_carve_nonzero, res_valid && carved, wall_col != '0 && wall_row != '0)

endmodule

bind union_find_maze_carver ufmc_checker u_ufmc_checker (.*);
